### rtl/fsmix_pkg.sv
// constants and helper functions for the fugue super-mix datapath
package fsmix_pkg;

  // four 32-bit column words, index 0 is the first word
  typedef logic [3:0][31:0] block_t;

  localparam logic [8:0] GF_POLY = 9'h11b;

  // aes s-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // multiply by x modulo the field polynomial
  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // product with the circulant coefficient column 1,1,7,4
  function automatic logic [7:0] coef_mul(logic [7:0] s, logic [1:0] idx);
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] prod;
    x2 = xtime(s);
    x4 = xtime(x2);
    unique case (idx)
      2'd0, 2'd1: prod = s;
      2'd2:       prod = x4 ^ x2 ^ s;
      default:    prod = x4;
    endcase
    return prod;
  endfunction

  // mix word for byte v at position k of its word (position 0 is bits 31..24)
  function automatic logic [31:0] mix_entry(logic [1:0] k, logic [7:0] v);
    logic [7:0]  s;
    logic [31:0] w;
    logic [1:0]  idx;
    s = SBOX[v];
    w = '0;
    for (int p = 0; p < 4; p++) begin
      idx = 2'(p) - k;
      w[31-8*p -: 8] = coef_mul(s, idx);
    end
    return w;
  endfunction

  // 4x4 byte matrix transpose: byte j of word i goes to byte i of word j
  function automatic block_t transpose(block_t b);
    block_t t;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        t[j][31-8*i -: 8] = b[i][31-8*j -: 8];
      end
    end
    return t;
  endfunction

endpackage

### rtl/fugue_super_mix_unit.sv
// fugue super-mix unit: one 128-bit column block in, the super-mixed block out
// Takes one block per clock while the output side is not stalled; each block passes
// the input and then the output register. The input register feeds one stage of
// logic (sixteen s-box lookups, constant field products by 1, 4 and 7, the column
// xors, transposes and cross-column terms) into the output register, and that stage
// sets the clock. An output register and an input register part the two sides, so a
// new block is taken while a finished one still waits to be taken.
module fugue_super_mix_unit
  import fsmix_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  input  logic [31:0] in_word2,
  input  logic [31:0] in_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3
);

  logic        stage_valid;
  block_t      stage_block;
  logic        advance;
  block_t      mixed;
  logic [31:0] mu [4][4];

  // stage moves forward when the output register is free or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_block <= {in_word3, in_word2, in_word1, in_word0};
    end
  end

  always_comb begin
    block_t colsum;
    block_t t;
    for (int r = 0; r < 4; r++) begin
      colsum[r] = '0;
      for (int k = 0; k < 4; k++) begin
        mu[r][k]  = mix_entry(2'(k), stage_block[r][31-8*k -: 8]);
        colsum[r] = colsum[r] ^ mu[r][k];
      end
    end
    t = transpose(colsum);
    // fold in the cross-column terms
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 4; r++) begin
        if (r != k) begin
          t[k] = t[k] ^ mu[r][k];
        end
      end
    end
    t[1] = {t[1][23:0], t[1][31:24]};
    t[2] = {t[2][15:0], t[2][31:16]};
    t[3] = {t[3][7:0],  t[3][31:8]};
    mixed = transpose(t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
    if (advance && stage_valid) begin
      out_word0 <= mixed[0];
      out_word1 <= mixed[1];
      out_word2 <= mixed[2];
      out_word3 <= mixed[3];
    end
  end

endmodule

### rtl/fsmix_check.sv
// port-level checks for the fugue super-mix unit and their bind
module fsmix_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word0,
  input logic [31:0] out_word1,
  input logic [31:0] out_word2,
  input logic [31:0] out_word3
);

  // no result shows right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word0) && $stable(out_word1)
      && $stable(out_word2) && $stable(out_word3))
    else $error("stalled result changed");

  // with the output register empty the input side is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // an accepted block passes the input register into the output register if the output side keeps taking
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after transfer");

endmodule

bind fugue_super_mix_unit fsmix_check u_fsmix_check (.*);

### tb/tb_top.sv
// self-checking testbench for the fugue super-mix unit
module tb_top;
  import fsmix_pkg::block_t;

  localparam int          NUM_RANDOM  = 1130;
  localparam int          MAX_WAIT    = 17;
  localparam int          HOLD_CYCLES = 120;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          DRAIN       = 10;
  localparam logic [8:0]  FIELD_POLY  = 9'h11b;
  localparam logic [7:0]  AFFINE_C    = 8'h63;
  // circulant coefficients for a byte in position 0, first output byte first
  localparam logic [7:0]  COEF [4]    = '{8'd1, 8'd1, 8'd7, 8'd4};

  class smix_scoreboard;
    logic [7:0] sbox_tbl [256];
    block_t     mixed_q [$];
    int         errors;

    function new();
      logic [7:0] inv;
      errors = 0;
      // s-box rebuilt from the field inverse and the affine map
      for (int v = 0; v < 256; v++) begin
        inv = 8'h00;
        for (int c = 1; c < 256; c++)
          if (gmul(8'(v), 8'(c)) == 8'h01) inv = 8'(c);
        sbox_tbl[v] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^
                      rotl8(inv, 4) ^ AFFINE_C;
      end
    endfunction

    function logic [7:0] rotl8(logic [7:0] x, int n);
      return (x << n) | (x >> (8 - n));
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) acc ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
      end
      return acc;
    endfunction

    function logic [31:0] mix_word(int k, logic [7:0] v);
      logic [7:0]  s;
      logic [31:0] w;
      s = sbox_tbl[v];
      w = '0;
      for (int p = 0; p < 4; p++)
        w[31-8*p -: 8] = gmul(s, COEF[(p - k) & 3]);
      return w;
    endfunction

    function block_t transpose_block(block_t b);
      block_t t;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          t[j][31-8*i -: 8] = b[i][31-8*j -: 8];
      return t;
    endfunction

    function block_t super_mix(block_t blk);
      logic [31:0] mu [4][4];
      block_t      w;
      for (int r = 0; r < 4; r++) begin
        w[r] = '0;
        for (int k = 0; k < 4; k++) begin
          mu[r][k] = mix_word(k, blk[r][31-8*k -: 8]);
          w[r] ^= mu[r][k];
        end
      end
      w = transpose_block(w);
      // cross-column terms
      for (int k = 0; k < 4; k++)
        for (int r = 0; r < 4; r++)
          if (r != k) w[k] ^= mu[r][k];
      w[1] = {w[1][23:0], w[1][31:24]};
      w[2] = {w[2][15:0], w[2][31:16]};
      w[3] = {w[3][7:0], w[3][31:8]};
      return transpose_block(w);
    endfunction

    function void note_input(block_t blk);
      mixed_q.push_back(super_mix(blk));
    endfunction

    function void check_output(block_t got);
      block_t want;
      if (mixed_q.size() == 0) begin
        $error("output transfer with no block outstanding: %h", got);
        errors++;
        return;
      end
      want = mixed_q.pop_front();
      for (int i = 0; i < 4; i++)
        if (got[i] !== want[i]) begin
          $error("out_word%0d: expected %h, got %h", i, want[i], got[i]);
          errors++;
        end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_word0 = '0;
  logic [31:0] in_word1 = '0;
  logic [31:0] in_word2 = '0;
  logic [31:0] in_word3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;

  smix_scoreboard sb;
  bit             hold_req = 1'b0;
  int             idle_cycles = 0;
  int             rx_count = 0;

  fugue_super_mix_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word0  (in_word0),
    .in_word1  (in_word1),
    .in_word2  (in_word2),
    .in_word3  (in_word3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .out_word2 (out_word2),
    .out_word3 (out_word3)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_input({in_word3, in_word2, in_word1, in_word0});
    if (!rst && out_valid && out_ready) begin
      sb.check_output({out_word3, out_word2, out_word1, out_word0});
      rx_count++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_block(input block_t blk, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word0 <= blk[0];
    in_word1 <= blk[1];
    in_word2 <= blk[2];
    in_word3 <= blk[3];
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w[31-8*$urandom_range(0, 3) -: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: ;
    endcase
    return w;
  endfunction

  // receiver: random stall per transfer, stretches with no stall, one long hold-off
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if ((rx_count / 50) % 4 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    block_t directed [$];
    block_t blk;
    int     gap;
    sb = new();
    directed.push_back({32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000});
    directed.push_back({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
    directed.push_back({32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
    directed.push_back({32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
    directed.push_back({32'h0c0d0e0f, 32'h08090a0b, 32'h04050607, 32'h00010203});
    directed.push_back({32'h00000000, 32'h00000000, 32'h00000000, 32'hff000000});
    directed.push_back({32'h00000000, 32'h00000000, 32'h00ff0000, 32'h00000000});
    directed.push_back({32'h00000000, 32'h0000ff00, 32'h00000000, 32'h00000000});
    directed.push_back({32'h000000ff, 32'h00000000, 32'h00000000, 32'h00000000});
    // s-box gives zero for this byte value
    directed.push_back({32'h52525252, 32'h52525252, 32'h52525252, 32'h52525252});
    directed.push_back({32'h52525252, 32'h52525252, 32'h52525252, 32'h52525201});
    directed.push_back({32'h80808080, 32'h01010101, 32'h7f7f7f7f, 32'hfefefefe});
    directed.push_back({32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000});
    directed.push_back({32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff});
    directed.push_back({32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210});
    directed.push_back({32'h8d8d8d8d, 32'h1b1b1b1b, 32'hc6c6c6c6, 32'h63636363});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_block(directed[i], $urandom_range(0, 3));

    for (int i = 0; i < NUM_RANDOM; i++) begin
      blk = {rand_word(), rand_word(), rand_word(), rand_word()};
      if (i == 300) hold_req = 1'b1;
      if (i >= 300 && i < 340)
        gap = 0;
      else if ((i / 64) % 4 == 1)
        gap = 0;
      else
        gap = $urandom_range(0, MAX_WAIT);
      send_block(blk, gap);
    end
    in_valid <= 1'b0;

    while (sb.mixed_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### fugue_super_mix_unit.f
rtl/fsmix_pkg.sv
rtl/fugue_super_mix_unit.sv
rtl/fsmix_check.sv
tb/tb_top.sv
